FILE: sv/qlbs_pkg.sv
// Package with the item types and codes shared by the blink sequencer modules.
package qlbs_pkg;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam int MS_W    = 16;
    localparam int COUNT_W = 8;
    localparam int LEVEL_W = 2;
    localparam int LEVEL_MAX = 3;

    typedef struct packed {
        logic [COUNT_W-1:0] blink_count;
        logic [MS_W-1:0]    on_ticks;
        logic [MS_W-1:0]    off_ticks;
    } request_t;

    typedef struct packed {
        logic     kind;
        request_t req;
    } item_t;

    typedef struct packed {
        logic               busy_res;
        logic [LEVEL_W-1:0] queue_level;
        logic               request_dropped;
        logic               led_on;
    } result_t;

endpackage

FILE: sv/qlbs_front.sv
// Front end: takes requests and ticks, converts millisecond times into tick counts.
module qlbs_front #(
    parameter int TICK_MS = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_kind,
    input  logic [7:0]         in_count,
    input  logic [15:0]        in_on_ms,
    input  logic [15:0]        in_off_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output qlbs_pkg::item_t    out_item
);

    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TICK_MS + 64'd1);

    logic              stage_valid_reg;
    qlbs_pkg::item_t   stage_item_reg;
    qlbs_pkg::item_t   stage_item_next;
    logic [48:0]       on_prod;
    logic [48:0]       off_prod;
    logic [15:0]       on_q;
    logic [15:0]       off_q;
    logic              take;

    assign in_ready = !stage_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Multiplying by the rounded-up reciprocal gives the exact quotient for 16-bit times.
    assign on_prod  = 49'(in_on_ms) * 49'(RECIP);
    assign off_prod = 49'(in_off_ms) * 49'(RECIP);
    assign on_q     = on_prod[47:32];
    assign off_q    = off_prod[47:32];

    always_comb begin
        stage_item_next.kind            = in_kind;
        stage_item_next.req.blink_count = in_count;
        stage_item_next.req.on_ticks    = (on_q == 16'd0) ? 16'd1 : on_q;
        stage_item_next.req.off_ticks   = (off_q == 16'd0) ? 16'd1 : off_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (in_ready) begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            stage_item_reg <= stage_item_next;
        end
    end

    assign out_valid = stage_valid_reg;
    assign out_item  = stage_item_reg;

endmodule

FILE: sv/qlbs_queue.sv
// Two-entry queue that parts the front end from the sequencer.
module qlbs_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  qlbs_pkg::item_t    in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output qlbs_pkg::item_t    out_item
);

    qlbs_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            push;
    logic            pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: sv/qlbs_back.sv
// Sequencer: request queue, blink timing and the registered result.
module qlbs_back #(
    parameter int QUEUE_DEPTH = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  qlbs_pkg::item_t    in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output qlbs_pkg::result_t  out_result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    qlbs_pkg::request_t pend_mem [QUEUE_DEPTH];

    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [7:0]     blinks_reg, blinks_next;
    logic [15:0]    phase_reg, phase_next;
    logic [15:0]    on_ticks_reg, on_ticks_next;
    logic [15:0]    off_ticks_reg, off_ticks_next;
    logic           led_reg, led_next;
    logic           running_reg, running_next;
    logic           res_valid_reg;
    qlbs_pkg::result_t res_reg, res_next;

    logic               fire;
    logic               is_req;
    logic               full;
    logic               wr_en;
    logic [15:0]        phase_dec;
    logic [7:0]         blinks_dec;
    qlbs_pkg::request_t head;

    assign in_ready = !res_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign is_req   = (in_item.kind == qlbs_pkg::KIND_REQUEST);
    assign full     = (cnt_reg == CW'(QUEUE_DEPTH));
    assign wr_en    = fire && is_req && !full;

    // An empty queue hands the arriving request straight through.
    assign head = (cnt_reg == '0) ? in_item.req : pend_mem[rd_ptr_reg];

    assign phase_dec  = (phase_reg != 16'd0) ? phase_reg - 16'd1 : 16'd0;
    assign blinks_dec = (blinks_reg != 8'd0) ? blinks_reg - 8'd1 : 8'd0;

    always_comb begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        cnt_next       = cnt_reg;
        blinks_next    = blinks_reg;
        phase_next     = phase_reg;
        on_ticks_next  = on_ticks_reg;
        off_ticks_next = off_ticks_reg;
        led_next       = led_reg;
        running_next   = running_reg;

        if (is_req) begin
            if (!full) begin
                wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                cnt_next    = cnt_reg + 1'b1;
            end
        end else if (running_reg) begin
            phase_next = phase_dec;
            if (phase_dec == 16'd0) begin
                if (led_reg) begin
                    led_next   = 1'b0;
                    phase_next = off_ticks_reg;
                end else begin
                    blinks_next = blinks_dec;
                    if (blinks_dec != 8'd0) begin
                        led_next   = 1'b1;
                        phase_next = on_ticks_reg;
                    end else begin
                        running_next = 1'b0;
                    end
                end
            end
        end

        if (!running_next && cnt_next != '0) begin
            rd_ptr_next    = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next       = cnt_next - 1'b1;
            on_ticks_next  = head.on_ticks;
            off_ticks_next = head.off_ticks;
            blinks_next    = head.blink_count;
            running_next   = 1'b1;
            if (head.blink_count == 8'd0) begin
                led_next   = 1'b0;
                phase_next = 16'd1;
            end else begin
                led_next   = 1'b1;
                phase_next = head.on_ticks;
            end
        end

        res_next.led_on          = led_next;
        res_next.request_dropped = is_req && full;
        res_next.queue_level     = (32'(cnt_next) > qlbs_pkg::LEVEL_MAX)
                                   ? 2'(qlbs_pkg::LEVEL_MAX) : 2'(cnt_next);
        res_next.busy_res        = running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cnt_reg       <= '0;
            blinks_reg    <= 8'd0;
            phase_reg     <= 16'd0;
            on_ticks_reg  <= 16'd0;
            off_ticks_reg <= 16'd0;
            led_reg       <= 1'b0;
            running_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
                cnt_reg       <= cnt_next;
                blinks_reg    <= blinks_next;
                phase_reg     <= phase_next;
                on_ticks_reg  <= on_ticks_next;
                off_ticks_reg <= off_ticks_next;
                led_reg       <= led_next;
                running_reg   <= running_next;
            end
            if (in_ready) begin
                res_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pend_mem[wr_ptr_reg] <= in_item.req;
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("request queue count beyond its depth");

    a_idle_led_off: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> !led_reg)
        else $error("LED lit while the sequencer is idle");

    a_idle_queue_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> cnt_reg == '0)
        else $error("sequencer idle with requests waiting");

    a_idle_request_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_req && !running_reg) |=> running_reg)
        else $error("request arriving while idle did not start");

endmodule

FILE: sv/queued_led_blink_sequencer_unit.sv
// Top level of the queued LED blink sequencer.
//
//  channel | ports                | contents
//  --------+----------------------+-------------------------------------------
//  input   | s_tvalid/s_tready    | tuser: kind; tdata: count, on ms, off ms
//  result  | m_tvalid/m_tready    | tdata: led, dropped, queue level, busy
//
// One item a cycle is sustained while m_tready is high; each item passes the
// input stage, the two-entry queue and the sequencer with its result register.
// The rate is set by the sequencer, which updates its queue and timers once
// per item, request or tick. Reset is synchronous and clears all control state.
// A stalled result side fills the queue and then holds s_tready low.
module queued_led_blink_sequencer_unit #(
    parameter int QUEUE_DEPTH = 3,
    parameter int TICK_MS     = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // blink_count[7:0], on_ms[23:8], off_ms[39:24]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // led_on[0], request_dropped[1], queue_level[3:2],
                                   // busy_res[4], zero[7:5]
);

    logic               f_valid, f_ready;
    qlbs_pkg::item_t    f_item;
    logic               q_valid, q_ready;
    qlbs_pkg::item_t    q_item;
    qlbs_pkg::result_t  result;

    qlbs_front #(
        .TICK_MS(TICK_MS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser[0]),
        .in_count (s_tdata[7:0]),
        .in_on_ms (s_tdata[23:8]),
        .in_off_ms(s_tdata[39:24]),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_item (f_item)
    );

    qlbs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_item  (f_item),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_item (q_item)
    );

    qlbs_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_result(result)
    );

    assign m_tdata = {3'd0, result};

endmodule

FILE: verif/queued_led_blink_sequencer_unit_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the sequencer's status after each input item and compares it on the result channel.
module queued_led_blink_sequencer_unit_checker #(
    parameter int QUEUE_DEPTH = 3,
    parameter int TICK_MS     = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // blink_count[7:0], on_ms[23:8], off_ms[39:24]
    input  logic [0:0]  s_tuser,   // kind[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // led_on[0], request_dropped[1], queue_level[3:2],
                                   // busy_res[4], zero[7:5]
    output int          mismatch_total,
    output int          status_due_count,
    output int          started_total,
    output int          dropped_total
);

    typedef logic [qlbs_pkg::MS_W-1:0]    ticks_t;
    typedef logic [qlbs_pkg::LEVEL_W-1:0] level_t;

    qlbs_pkg::request_t           held_reqs [QUEUE_DEPTH];
    int                           head_slot;
    int                           waiting;
    logic [qlbs_pkg::COUNT_W-1:0] blinks_to_go;
    ticks_t                       ticks_to_go;
    ticks_t                       on_len;
    ticks_t                       off_len;
    logic                         led_lit;
    logic                         playing;
    qlbs_pkg::result_t            status_due [$];
    int                           result_index;

    function automatic ticks_t phase_len(ticks_t ms);
        int t;
        t = int'(ms) / TICK_MS;
        return (t == 0) ? ticks_t'(1) : ticks_t'(t);
    endfunction

    task automatic take_oldest();
        qlbs_pkg::request_t r;
        if (playing || waiting == 0)
            return;
        r = held_reqs[head_slot];
        head_slot = (head_slot + 1) % QUEUE_DEPTH;
        waiting--;
        on_len = phase_len(r.on_ticks);
        off_len = phase_len(r.off_ticks);
        blinks_to_go = r.blink_count;
        playing = 1'b1;
        started_total++;
        if (r.blink_count == '0) begin
            led_lit = 1'b0;
            ticks_to_go = ticks_t'(1);
        end else begin
            led_lit = 1'b1;
            ticks_to_go = on_len;
        end
    endtask

    task automatic count_tick();
        if (!playing)
            return;
        if (ticks_to_go > 0)
            ticks_to_go--;
        if (ticks_to_go != 0)
            return;
        if (led_lit) begin
            led_lit = 1'b0;
            ticks_to_go = off_len;
            return;
        end
        if (blinks_to_go > 0)
            blinks_to_go--;
        if (blinks_to_go > 0) begin
            led_lit = 1'b1;
            ticks_to_go = on_len;
        end else begin
            playing = 1'b0;
        end
    endtask

    task automatic predict_status(logic kind, logic [39:0] data, output qlbs_pkg::result_t st);
        qlbs_pkg::request_t r;
        logic               lost;
        lost = 1'b0;
        if (kind == qlbs_pkg::KIND_REQUEST) begin
            if (waiting >= QUEUE_DEPTH) begin
                lost = 1'b1;
                dropped_total++;
            end else begin
                r.blink_count = data[7:0];
                r.on_ticks = data[23:8];
                r.off_ticks = data[39:24];
                held_reqs[(head_slot + waiting) % QUEUE_DEPTH] = r;
                waiting++;
            end
        end else begin
            count_tick();
        end
        take_oldest();
        st.led_on = led_lit;
        st.request_dropped = lost;
        st.queue_level = (waiting > qlbs_pkg::LEVEL_MAX) ? level_t'(qlbs_pkg::LEVEL_MAX)
                                                         : level_t'(waiting);
        st.busy_res = playing;
    endtask

    task automatic report_mismatch(string what, int want, int got);
        mismatch_total++;
        if (mismatch_total <= 40)
            $display("%0t ns: result %0d, %s: expected %0d, got %0d",
                     $time, result_index, what, want, got);
    endtask

    always @(posedge aclk) begin : watch
        qlbs_pkg::result_t want;
        qlbs_pkg::result_t got;
        qlbs_pkg::result_t st;
        if (!aresetn) begin
            head_slot = 0;
            waiting = 0;
            blinks_to_go = '0;
            ticks_to_go = '0;
            on_len = '0;
            off_len = '0;
            led_lit = 1'b0;
            playing = 1'b0;
            status_due.delete();
            result_index = 0;
            mismatch_total = 0;
            started_total = 0;
            dropped_total = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = qlbs_pkg::result_t'(m_tdata[4:0]);
                if (status_due.size() == 0) begin
                    report_mismatch("status with nothing outstanding", 0, int'(m_tdata));
                end else begin
                    want = status_due.pop_front();
                    if (got.led_on !== want.led_on)
                        report_mismatch("led_on", int'(want.led_on), int'(got.led_on));
                    if (got.request_dropped !== want.request_dropped)
                        report_mismatch("request_dropped", int'(want.request_dropped),
                                        int'(got.request_dropped));
                    if (got.queue_level !== want.queue_level)
                        report_mismatch("queue_level", int'(want.queue_level),
                                        int'(got.queue_level));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", int'(want.busy_res), int'(got.busy_res));
                    if (m_tdata[7:5] !== 3'b000)
                        report_mismatch("padding bits", 0, int'(m_tdata[7:5]));
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                predict_status(s_tuser[0], s_tdata, st);
                status_due.push_back(st);
            end
        end
        status_due_count <= status_due.size();
    end

endmodule

FILE: verif/queued_led_blink_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top that feeds timer ticks and blink requests to the sequencer and gives the verdict.
module queued_led_blink_sequencer_unit_tb;

    localparam int QUEUE_DEPTH  = 3;
    localparam int TICK_MS      = 1;
    localparam int STALL_PCT    = 30;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1575;
    localparam int WIDE_ITEMS   = 125;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        no_stall;
    int          quiet_cycles;
    int          items_sent;
    int          requests_sent;
    int          mismatch_total;
    int          status_due_count;
    int          started_total;
    int          dropped_total;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    queued_led_blink_sequencer_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICK_MS     (TICK_MS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    queued_led_blink_sequencer_unit_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICK_MS     (TICK_MS)
    ) status_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_total   (mismatch_total),
        .status_due_count (status_due_count),
        .started_total    (started_total),
        .dropped_total    (dropped_total)
    );

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= no_stall || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge aclk) begin
        if (!aresetn)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles without a request or result moving.",
                     quiet_cycles);
            $display("queued_led_blink_sequencer_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic offer_item(logic kind, logic [39:0] data);
        while (!no_stall && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (kind == qlbs_pkg::KIND_REQUEST)
            requests_sent++;
    endtask

    task automatic blink_request(logic [7:0] cnt, logic [15:0] on_ms, logic [15:0] off_ms);
        offer_item(qlbs_pkg::KIND_REQUEST, {off_ms, on_ms, cnt});
    endtask

    task automatic timer_tick();
        offer_item(qlbs_pkg::KIND_TICK, {8'($urandom), 32'($urandom)});
    endtask

    function automatic logic [15:0] narrow_ms();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 16'($urandom_range(3));
        if (r < 97)
            return 16'($urandom_range(20, 4));
        return 16'($urandom_range(300));
    endfunction

    initial begin : stimulus
        int request_pct;
        int r;
        items_sent = 0;
        requests_sent = 0;
        request_pct = 12;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= qlbs_pkg::KIND_TICK;
        s_tdata <= '0;
        no_stall <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // A tick while idle, a zero count, and one-tick phases from zero times.
        timer_tick();
        blink_request(8'd0, 16'd0, 16'd0);
        timer_tick();
        blink_request(8'd1, 16'd0, 16'd0);
        timer_tick();
        timer_tick();
        // Fill the queue behind a running request, then overflow it with extreme values.
        blink_request(8'd2, 16'd2, 16'd1);
        blink_request(8'd1, 16'd1, 16'd3);
        blink_request(8'd0, 16'd5, 16'd5);
        blink_request(8'd3, 16'd1, 16'd1);
        blink_request(8'hFF, 16'hFFFF, 16'hFFFF);
        blink_request(8'h55, 16'hAAAA, 16'h5555);
        // Start the queued requests in turn, each on the tick that ends the one before.
        repeat (13) timer_tick();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(2))
                    0: request_pct = 4;
                    1: request_pct = 12;
                    default: request_pct = 30;
                endcase
            end
            no_stall <= (i >= 500 && i < 800);
            if ($urandom_range(99) >= request_pct) begin
                timer_tick();
            end else if (i >= RANDOM_ITEMS - WIDE_ITEMS) begin
                blink_request(8'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                r = $urandom_range(99);
                if (r < 75)
                    blink_request(8'($urandom_range(3)), narrow_ms(), narrow_ms());
                else if (r < 98)
                    blink_request(8'($urandom_range(12, 4)), narrow_ms(), narrow_ms());
                else
                    blink_request(8'($urandom_range(255, 16)), 16'd0, 16'd0);
            end
        end
        s_tvalid <= 1'b0;

        do
            @(posedge aclk);
        while (status_due_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items, %0d of them blink requests: %0d played, %0d dropped.",
                 items_sent, requests_sent, started_total, dropped_total);
        $display("Covered zero counts, one-tick phases, full-queue drops and stalls on both sides.");
        if (mismatch_total == 0 && status_due_count == 0) begin
            $display("queued_led_blink_sequencer_unit_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d results still outstanding.",
                     mismatch_total, status_due_count);
            $display("queued_led_blink_sequencer_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/qlbs_pkg.sv
sv/qlbs_front.sv
sv/qlbs_queue.sv
sv/qlbs_back.sv
sv/queued_led_blink_sequencer_unit.sv
verif/queued_led_blink_sequencer_unit_checker.sv
verif/queued_led_blink_sequencer_unit_tb.sv
